@@ sv/idc_pkg.sv @@
package idc_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;

    typedef logic [1:0] t_req_type;

    localparam int REQ_SIGNED_BIT = 0;
    localparam int REQ_COMMAS_BIT = 1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_COMMA
    } t_state;

endpackage

@@ sv/integer_to_decimal_ascii_with_commas.sv @@
// Channel   Direction  Handshake                     Payload
// request   in         start & !busy                 i_req_type, i_value
// result    out        o_valid, one cycle per char   o_ascii_char, o_last
//
// A request first runs VALUE_WIDTH shift-and-adjust steps in the BCD unit,
// then a leading-zero scan that drops the zero digits above the lowest one,
// then the emission of the characters (up to 26 at the default width).
// Busy is high from the cycle after acceptance through the final character;
// the next request is taken in the cycle after the final character at the earliest.
// Reset (synchronous, active low) returns the sequencer to idle.
// The receiver cannot stall: every character is taken in the cycle it is shown.
module integer_to_decimal_ascii_with_commas #(
    parameter int VALUE_WIDTH = idc_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  idc_pkg::t_req_type  i_req_type,
    input  logic [63:0]         i_value,
    output logic                o_valid,
    output logic [7:0]          o_ascii_char,
    output logic                o_last
);
    import idc_pkg::*;

    localparam int NDIG    = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BW      = 4 * NDIG;
    localparam int IW      = $clog2(NDIG);
    localparam int CW      = $clog2(VALUE_WIDTH + 1);
    localparam logic [IW-1:0] IDX_TOP = IW'(NDIG - 1);
    localparam logic [1:0]    MOD_TOP = 2'((NDIG - 1) % 3);
    localparam logic [CW-1:0] CNT_TOP = CW'(VALUE_WIDTH);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [IW-1:0]          r_idx, n_idx;
    logic [1:0]             r_mod, n_mod;
    logic                   r_neg, n_neg;
    logic                   r_commas, n_commas;

    logic [VALUE_WIDTH-1:0] in_bits;
    logic                   in_neg;
    logic [BW-1:0]          bcd_adj;
    logic [3:0]             cur_digit;

    assign in_bits   = i_value[VALUE_WIDTH-1:0];
    assign in_neg    = i_req_type[REQ_SIGNED_BIT] & in_bits[VALUE_WIDTH-1];
    assign cur_digit = r_bcd[4*r_idx +: 4];

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_mod    <= n_mod;
        r_neg    <= n_neg;
        r_commas <= n_commas;
    end

    always_comb begin
        n_state      = r_state;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_mod        = r_mod;
        n_neg        = r_neg;
        n_commas     = r_commas;
        busy         = 1'b1;
        o_valid      = 1'b0;
        o_ascii_char = CH_ZERO;
        o_last       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_bin    = in_neg ? (~in_bits + 1'b1) : in_bits;
                    n_bcd    = '0;
                    n_cnt    = CNT_TOP;
                    n_idx    = IDX_TOP;
                    n_mod    = MOD_TOP;
                    n_neg    = in_neg;
                    n_commas = i_req_type[REQ_COMMAS_BIT];
                    n_state  = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[BW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (cur_digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                    n_mod = (r_mod == 2'd0) ? 2'd2 : r_mod - 2'd1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                o_valid      = 1'b1;
                o_ascii_char = CH_MINUS;
                n_state      = ST_DIGIT;
            end
            ST_DIGIT: begin
                o_valid      = 1'b1;
                o_ascii_char = CH_ZERO + {4'd0, cur_digit};
                o_last       = (r_idx == '0);
                priority if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end else if (r_commas && r_mod == 2'd0) begin
                    n_state = ST_COMMA;
                end else begin
                    n_idx = r_idx - 1'b1;
                    n_mod = (r_mod == 2'd0) ? 2'd2 : r_mod - 2'd1;
                end
            end
            ST_COMMA: begin
                o_valid      = 1'b1;
                o_ascii_char = CH_COMMA;
                n_idx        = r_idx - 1'b1;
                n_mod        = 2'd2;
                n_state      = ST_DIGIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("request accepted but sequencer not busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !busy)
        else $error("sequencer still busy after final character");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid && o_ascii_char >= CH_ZERO && o_ascii_char <= CH_NINE)
        else $error("final character is not a digit");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("character shown while idle");

endmodule

@@ sim/tb.sv @@
module tb;
    import idc_pkg::*;

    localparam int VW         = DEFAULT_VALUE_WIDTH;
    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 310;
    localparam int N_CALM     = 40;
    localparam int MAX_DIGITS = 20;

    localparam t_req_type FMT_UNSIGNED        = 2'd0;
    localparam t_req_type FMT_SIGNED          = 2'd1;
    localparam t_req_type FMT_UNSIGNED_COMMAS = 2'd2;
    localparam t_req_type FMT_SIGNED_COMMAS   = 2'd3;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_out_char;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    t_req_type   i_req_type = FMT_UNSIGNED;
    logic [63:0] i_value    = '0;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_ascii_char;
    logic        o_last;

    t_out_char pending_chars[$];
    int        errors = 0;
    bit        calm   = 1'b0;

    t_req_type dir_type [N_DIRECTED] = '{
        FMT_UNSIGNED, FMT_SIGNED, FMT_UNSIGNED_COMMAS, FMT_SIGNED_COMMAS,
        FMT_UNSIGNED, FMT_UNSIGNED_COMMAS, FMT_SIGNED, FMT_SIGNED_COMMAS,
        FMT_SIGNED, FMT_SIGNED_COMMAS, FMT_SIGNED, FMT_SIGNED_COMMAS,
        FMT_UNSIGNED, FMT_UNSIGNED_COMMAS, FMT_UNSIGNED_COMMAS, FMT_SIGNED_COMMAS,
        FMT_SIGNED_COMMAS, FMT_UNSIGNED, FMT_UNSIGNED, FMT_UNSIGNED_COMMAS,
        FMT_SIGNED, FMT_UNSIGNED
    };

    logic [63:0] dir_value [N_DIRECTED] = '{
        64'd0, 64'd0, 64'd0, 64'd0,
        ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
        MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
        MOST_NEG, 64'd999, 64'd1000, 64'hFFFF_FFFF_FFFF_FC18,
        64'hFFFF_FFFF_FFFF_FC19, 64'd9, 64'd10, 64'd1234567,
        64'hFFFF_FFFF_F8A4_32EB, 64'h0123_4567_89AB_CDEF
    };

    string dir_text [N_DIRECTED] = '{
        "0", "0", "0", "0",
        "18446744073709551615", "18,446,744,073,709,551,615", "-1", "-1",
        "-9223372036854775808", "-9,223,372,036,854,775,808",
        "9223372036854775807", "9,223,372,036,854,775,807",
        "9223372036854775808", "999", "1,000", "-1,000",
        "-999", "9", "10", "",
        "", ""
    };

    always #10 i_clk = ~i_clk;

    integer_to_decimal_ascii_with_commas #(
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_chars.push_back(t_out_char'{ch: s[i], last: (i == s.len() - 1)});
        end
    endfunction

    function automatic void format_decimal(t_req_type rt, logic [63:0] value);
        logic [63:0] mask;
        logic [63:0] mag;
        logic        negative;
        logic [3:0]  digit [MAX_DIGITS];
        int          n;
        mask = (VW == 64) ? ALL_ONES : ((64'd1 << VW) - 64'd1);
        mag = value & mask;
        negative = rt[REQ_SIGNED_BIT] && mag[VW-1];
        if (negative) begin
            mag = (~mag + 64'd1) & mask;
        end
        n = 0;
        do begin
            digit[n] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            n++;
        end while (mag != 0 && n < MAX_DIGITS);
        if (negative) begin
            pending_chars.push_back(t_out_char'{ch: CH_MINUS, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            pending_chars.push_back(t_out_char'{ch: CH_ZERO + 8'(digit[i]), last: (i == 0)});
            if (rt[REQ_COMMAS_BIT] && i > 0 && (i % 3) == 0) begin
                pending_chars.push_back(t_out_char'{ch: CH_COMMA, last: 1'b0});
            end
        end
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: ;
            1: v = v >> $urandom_range(0, 63);
            2: v = 64'($urandom_range(0, 99999));
            3, 4: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v + 64'd1;
                end
            end
            5: v = 64'd0 - 64'($urandom_range(1, 99999));
            default: v = MOST_NEG + 64'($urandom_range(0, 2)) - 64'd1;
        endcase
        return v;
    endfunction

    task automatic send_request(t_req_type rt, logic [63:0] value, string text);
        @(negedge i_clk);
        start      = 1'b1;
        i_req_type = rt;
        i_value    = value;
        do @(posedge i_clk); while (busy);
        if (text.len() != 0) begin
            push_text(text);
        end else begin
            format_decimal(rt, value);
        end
        if (!calm && $urandom_range(0, 2) == 0) begin
            @(negedge i_clk);
            start      = 1'b0;
            i_req_type = t_req_type'($urandom_range(0, 3));
            i_value    = {$urandom, $urandom};
            while (busy) @(negedge i_clk);
            repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_char want;
        if (i_rst_n && o_valid) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char: expected none, got %h last %b",
                         $time, o_ascii_char, o_last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_ascii_char !== want.ch) begin
                    $display("%0t: ascii_char mismatch: expected %h, got %h",
                             $time, want.ch, o_ascii_char);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, want.last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int d = 0; d < N_DIRECTED; d++) begin
            send_request(dir_type[d], dir_value[d], dir_text[d]);
        end
        for (int r = 0; r < N_RANDOM; r++) begin
            calm = (r >= N_RANDOM - N_CALM);
            send_request(t_req_type'($urandom_range(0, 3)), random_value(), "");
        end
        @(negedge i_clk);
        start = 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("integer_to_decimal_ascii_with_commas verification clean");
        end else begin
            $display("integer_to_decimal_ascii_with_commas verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("integer_to_decimal_ascii_with_commas verification failed");
        $finish;
    end

endmodule
